/* rtl/sbdtd_pkg.sv */
// Shared types and constants for the six-bit dictionary text decoder.
// No dependencies; every other file of the block but sbdtd_ram refers to it by scoped names.
`timescale 1ns / 1ps

package sbdtd_pkg;

  // input item kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_DICT    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [5:0] CODE_MASK    = 6'h3f;
  localparam logic [5:0] ESCAPE_FIRST = 6'h3c;

  localparam int DICT_DEPTH = 59;
  localparam int DICT_AW    = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    OP_WR,   // dictionary write
    OP_LIT,  // character known up front (escape pair or end of string)
    OP_RD    // character from a dictionary lookup
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [7:0]           data;
    logic [DICT_AW-1:0]   addr;
    logic                 eos;
    logic                 last;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/sbdtd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module sbdtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sbdtd_front.sv */
// Front end: accepts items, splits the packed stream into 6-bit codes and
// turns each into an operation for the back end. Uses sbdtd_pkg.
`timescale 1ns / 1ps

module sbdtd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [7:0]          in_data_byte,
  input  logic [5:0]          in_dict_index,
  input  sbdtd_pkg::fifo_stat_t q_stat,
  output logic                q_push,
  output sbdtd_pkg::op_t      q_push_op
);

  logic [11:0] bit_buffer_r, bit_buffer_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic        esc_r, esc_nxt;
  logic [1:0]  esc_hi_r, esc_hi_nxt;

  sbdtd_pkg::op_t hold0_r, hold0_nxt;
  sbdtd_pkg::op_t hold1_r, hold1_nxt;
  logic [1:0]     hold_cnt_r, hold_cnt_nxt;

  logic           accept;
  sbdtd_pkg::op_t op_a, op_b;
  logic [1:0]     n_ops;

  function automatic sbdtd_pkg::op_t code_op(input logic esc, input logic [1:0] hi,
                                             input logic [5:0] code);
    sbdtd_pkg::op_t o;
    o.kind = sbdtd_pkg::OP_LIT;
    o.data = {hi, code};
    o.addr = code - 6'd1;
    o.eos  = 1'b0;
    o.last = 1'b0;
    if (!esc && code == 6'd0) begin
      o.data = 8'd0;
      o.eos  = 1'b1;
    end else if (!esc && code < sbdtd_pkg::ESCAPE_FIRST) begin
      o.kind = sbdtd_pkg::OP_RD;
    end
    return o;
  endfunction

  // ops leave the holding pair one per cycle while the queue is not full
  assign q_push    = (hold_cnt_r != 2'd0) && !q_stat.full;
  assign q_push_op = hold0_r;
  assign in_ready  = (hold_cnt_r == 2'd0) || ((hold_cnt_r == 2'd1) && q_push);
  assign accept    = in_valid && in_ready;

  always_comb begin
    logic [3:0]  bc;
    logic [11:0] bufw;
    logic [3:0]  cnt;
    logic [3:0]  cnt_f;
    logic [5:0]  code1;
    logic [5:0]  code2;
    logic        e;
    logic [1:0]  h;
    logic        stop;

    bc    = 4'd0;
    bufw  = 12'd0;
    cnt   = 4'd0;
    cnt_f = 4'd0;
    code1 = 6'd0;
    code2 = 6'd0;
    e     = 1'b0;
    h     = 2'd0;
    stop  = 1'b0;
    op_a  = '0;
    op_b  = '0;
    n_ops = 2'd0;

    bit_buffer_nxt = bit_buffer_r;
    bit_count_nxt  = bit_count_r;
    esc_nxt        = esc_r;
    esc_hi_nxt     = esc_hi_r;

    if (accept) begin
      case (in_kind)
        sbdtd_pkg::KIND_DICT: begin
          if (in_dict_index < 6'(sbdtd_pkg::DICT_DEPTH)) begin
            op_a.kind = sbdtd_pkg::OP_WR;
            op_a.data = in_data_byte;
            op_a.addr = in_dict_index;
            n_ops     = 2'd1;
          end
        end
        sbdtd_pkg::KIND_RESTART: begin
          bit_buffer_nxt = 12'd0;
          bit_count_nxt  = 4'd0;
          esc_nxt        = 1'b0;
          esc_hi_nxt     = 2'd0;
        end
        sbdtd_pkg::KIND_DATA: begin
          bc    = (bit_count_r > 4'd4) ? 4'd4 : bit_count_r;
          bufw  = {bit_buffer_r[3:0], in_data_byte};
          cnt   = bc + 4'd8;
          code1 = 6'((bufw >> (cnt - 4'd6)) & {6'd0, sbdtd_pkg::CODE_MASK});
          cnt_f = cnt - 4'd6;
          e     = esc_r;
          h     = esc_hi_r;

          if (e || code1 < sbdtd_pkg::ESCAPE_FIRST) begin
            op_a  = code_op(e, h, code1);
            n_ops = 2'd1;
          end
          stop = !e && (code1 == 6'd0);
          if (e) begin
            e = 1'b0;
            h = 2'd0;
          end else if (code1 >= sbdtd_pkg::ESCAPE_FIRST) begin
            e = 1'b1;
            h = code1[1:0];
          end

          // a full 12-bit buffer holds a second code in its low bits
          if (!stop && cnt_f >= 4'd6) begin
            code2 = bufw[5:0];
            cnt_f = cnt_f - 4'd6;
            if (e || code2 < sbdtd_pkg::ESCAPE_FIRST) begin
              if (n_ops == 2'd0) begin
                op_a = code_op(e, h, code2);
              end else begin
                op_b = code_op(e, h, code2);
              end
              n_ops = n_ops + 2'd1;
            end
            stop = !e && (code2 == 6'd0);
            if (e) begin
              e = 1'b0;
              h = 2'd0;
            end else if (code2 >= sbdtd_pkg::ESCAPE_FIRST) begin
              e = 1'b1;
              h = code2[1:0];
            end
          end

          if (stop) begin
            bit_buffer_nxt = 12'd0;
            bit_count_nxt  = 4'd0;
            esc_nxt        = 1'b0;
            esc_hi_nxt     = 2'd0;
          end else begin
            bit_buffer_nxt = bufw & ((12'd1 << cnt_f) - 12'd1);
            bit_count_nxt  = cnt_f;
            esc_nxt        = e;
            esc_hi_nxt     = h;
          end

          if (n_ops == 2'd1) begin
            op_a.last = 1'b1;
          end else if (n_ops == 2'd2) begin
            op_b.last = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    hold0_nxt    = hold0_r;
    hold1_nxt    = hold1_r;
    hold_cnt_nxt = hold_cnt_r;
    if (accept) begin
      hold0_nxt    = op_a;
      hold1_nxt    = op_b;
      hold_cnt_nxt = n_ops;
    end else if (q_push) begin
      hold0_nxt    = hold1_r;
      hold_cnt_nxt = hold_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_buffer_r <= 12'd0;
      bit_count_r  <= 4'd0;
      esc_r        <= 1'b0;
      esc_hi_r     <= 2'd0;
      hold_cnt_r   <= 2'd0;
    end else begin
      bit_buffer_r <= bit_buffer_nxt;
      bit_count_r  <= bit_count_nxt;
      esc_r        <= esc_nxt;
      esc_hi_r     <= esc_hi_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
    end
    hold0_r <= hold0_nxt;
    hold1_r <= hold1_nxt;
  end

endmodule

/* rtl/sbdtd_fifo.sv */
// Short operation queue between the front and back ends.
// Uses sbdtd_pkg for the operation type and depth.
`timescale 1ns / 1ps

module sbdtd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sbdtd_pkg::op_t        push_op,
  input  logic                  pop,
  output sbdtd_pkg::op_t        head_op,
  output sbdtd_pkg::fifo_stat_t stat
);

  sbdtd_pkg::op_t                mem_r [sbdtd_pkg::FIFO_DEPTH];
  logic [sbdtd_pkg::FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [sbdtd_pkg::FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic [sbdtd_pkg::FIFO_AW:0]   count_r, count_nxt;

  assign head_op    = mem_r[rptr_r];
  assign stat.full  = (count_r == (sbdtd_pkg::FIFO_AW + 1)'(sbdtd_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wptr_nxt  = push ? wptr_r + (sbdtd_pkg::FIFO_AW)'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + (sbdtd_pkg::FIFO_AW)'(1) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (sbdtd_pkg::FIFO_AW + 1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (sbdtd_pkg::FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

endmodule

/* rtl/sbdtd_back.sv */
// Back end: executes queued operations against the dictionary RAM and drives
// the result channel. Uses sbdtd_pkg and sbdtd_ram.
`timescale 1ns / 1ps

module sbdtd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sbdtd_pkg::op_t        head_op,
  input  sbdtd_pkg::fifo_stat_t q_stat,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char_out,
  output logic                  out_end_of_string,
  output logic                  out_last
);

  logic           s1_valid_r, s1_valid_nxt;
  sbdtd_pkg::op_t s1_op_r;
  logic           s1_adv;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r;
  logic       out_eos_r;
  logic       out_last_r;

  logic       ram_we, ram_re;
  logic [7:0] ram_rdata;
  logic       pop_emit;

  // writes retire at pop; characters pass through s1 while the RAM read lands
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign q_pop    = !q_stat.empty &&
                    ((head_op.kind == sbdtd_pkg::OP_WR) || !s1_valid_r || s1_adv);
  assign pop_emit = q_pop && (head_op.kind != sbdtd_pkg::OP_WR);
  assign ram_we   = q_pop && (head_op.kind == sbdtd_pkg::OP_WR);
  assign ram_re   = q_pop && (head_op.kind == sbdtd_pkg::OP_RD);

  sbdtd_ram #(
    .WIDTH (8),
    .DEPTH (sbdtd_pkg::DICT_DEPTH)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_op.addr),
    .wdata (head_op.data),
    .re    (ram_re),
    .raddr (head_op.addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (pop_emit) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (pop_emit) begin
      s1_op_r <= head_op;
    end
    if (s1_adv) begin
      out_char_r <= (s1_op_r.kind == sbdtd_pkg::OP_RD) ? ram_rdata : s1_op_r.data;
      out_eos_r  <= s1_op_r.eos;
      out_last_r <= s1_op_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char_out      = out_char_r;
  assign out_end_of_string = out_eos_r;
  assign out_last          = out_last_r;

  a_eos_zero_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_eos_r |-> (out_char_r == 8'd0) && out_last_r)
    else $error("end of string transfer without zero char or last");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced op did not reach output register");

endmodule

/* rtl/six_bit_dictionary_text_decoder.sv */
// Six-bit dictionary text decoder top level: front end, operation queue, back end.
// Uses sbdtd_pkg, sbdtd_front, sbdtd_fifo and sbdtd_back.
`timescale 1ns / 1ps

// Packed data bytes are split MSB-first into 6-bit codes; each code becomes a
// dictionary character, an escaped literal or the terminating zero, one result
// transfer each, with last marking the final character of an item. Dictionary
// writes and restarts give no result. An item that yields at most one character
// is accepted every cycle while the queue has room; a two-character byte holds
// off the next item until one of its operations has left, as the front end
// hands one operation per cycle to the four-entry queue. A character passes the
// holding pair, queue, s1 and output register. Dictionary writes take effect in
// queue order, so a lookup always sees every write accepted before it.
module six_bit_dictionary_text_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data_byte,
  input  logic [5:0] in_dict_index,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic       out_end_of_string,
  output logic       out_last
);

  sbdtd_pkg::fifo_stat_t q_stat;
  sbdtd_pkg::op_t        q_push_op;
  sbdtd_pkg::op_t        q_head_op;
  logic                  q_push;
  logic                  q_pop;

  sbdtd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_data_byte  (in_data_byte),
    .in_dict_index (in_dict_index),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_push_op     (q_push_op)
  );

  sbdtd_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .pop     (q_pop),
    .head_op (q_head_op),
    .stat    (q_stat)
  );

  sbdtd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_op           (q_head_op),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char_out      (out_char_out),
    .out_end_of_string (out_end_of_string),
    .out_last          (out_last)
  );

endmodule

/* test/tb.sv */
// Self-checking testbench for six_bit_dictionary_text_decoder.
// Depends on sbdtd_pkg and the RTL top level; predicts every character from a local decoder copy.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PLAN = 0;  // stream state as seen by the stimulus builder
  localparam int LIVE = 1;  // stream state as seen at the input transfer
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [5:0] idx;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       last;
  } char_rec_t;

  typedef char_rec_t [1:0] char_pair_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind = '0;
  logic [7:0] in_data_byte = '0;
  logic [5:0] in_dict_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char_out;
  logic       out_end_of_string;
  logic       out_last;

  six_bit_dictionary_text_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .in_dict_index     (in_dict_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char_out      (out_char_out),
    .out_end_of_string (out_end_of_string),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state, one copy for stimulus planning and one for checking
  logic [11:0] stream_bits [2];
  logic [3:0]  stream_cnt [2];
  logic        esc_pend [2];
  logic [1:0]  esc_hi [2];
  logic [7:0]  dict_val [2][sbdtd_pkg::DICT_DEPTH];
  logic        dict_set [2][sbdtd_pkg::DICT_DEPTH];

  in_item_t  pending_items [$];
  char_rec_t expected_chars [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_asks = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  int  items_queued = 0;
  int  items_taken = 0;
  int  chars_checked = 0;
  int  eos_checked = 0;
  int  pair_items = 0;
  int  mismatch_count = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Runs one item through the selected state copy; returns the character count.
  // reads flags every dictionary entry the item looked up.
  function automatic int decode_item(input int sel, input in_item_t it,
                                     output char_pair_t res,
                                     output logic [sbdtd_pkg::DICT_DEPTH-1:0] reads);
    int n;
    logic [11:0] bits;
    logic [4:0] cnt;
    logic [5:0] code;
    n = 0;
    res = '0;
    reads = '0;
    case (it.kind)
      sbdtd_pkg::KIND_DICT: begin
        if (it.idx < sbdtd_pkg::DICT_DEPTH) begin
          dict_val[sel][it.idx] = it.data;
          dict_set[sel][it.idx] = 1'b1;
        end
      end
      sbdtd_pkg::KIND_RESTART: begin
        stream_bits[sel] = '0;
        stream_cnt[sel] = '0;
        esc_pend[sel] = 1'b0;
        esc_hi[sel] = '0;
      end
      sbdtd_pkg::KIND_DATA: begin
        cnt = (stream_cnt[sel] > 4) ? 5'd4 : 5'(stream_cnt[sel]);
        bits = {stream_bits[sel][3:0], it.data};
        cnt = cnt + 5'd8;
        while (cnt >= 6) begin
          code = 6'(bits >> (cnt - 5'd6));
          cnt = cnt - 5'd6;
          bits = bits & ((12'd1 << cnt) - 12'd1);
          if (esc_pend[sel]) begin
            res[n] = '{ch: {esc_hi[sel], code}, eos: 1'b0, last: 1'b0};
            n++;
            esc_pend[sel] = 1'b0;
            esc_hi[sel] = '0;
          end else if (code == 6'd0) begin
            // end of string drops whatever is left in the byte
            res[n] = '{ch: 8'h00, eos: 1'b1, last: 1'b0};
            n++;
            bits = '0;
            cnt = '0;
            esc_pend[sel] = 1'b0;
            esc_hi[sel] = '0;
          end else if (code < sbdtd_pkg::ESCAPE_FIRST) begin
            reads[int'(code) - 1] = 1'b1;
            res[n] = '{ch: dict_val[sel][int'(code) - 1], eos: 1'b0, last: 1'b0};
            n++;
          end else begin
            esc_pend[sel] = 1'b1;
            esc_hi[sel] = code[1:0];
          end
        end
        stream_bits[sel] = bits;
        stream_cnt[sel] = 4'(cnt);
      end
      default: ;
    endcase
    if (n > 0) res[n-1].last = 1'b1;
    return n;
  endfunction

  // Queues one item; any dictionary entry it would read unwritten gets a write first.
  task automatic queue_item(input logic [1:0] kind, input logic [7:0] data,
                            input logic [5:0] idx);
    in_item_t it;
    char_pair_t res;
    logic [sbdtd_pkg::DICT_DEPTH-1:0] reads;
    int i;
    it = '{kind: kind, data: data, idx: idx};
    void'(decode_item(PLAN, it, res, reads));
    for (i = 0; i < sbdtd_pkg::DICT_DEPTH; i++) begin
      if (reads[i] && !dict_set[PLAN][i]) begin
        dict_set[PLAN][i] = 1'b1;
        pending_items.push_back('{kind: sbdtd_pkg::KIND_DICT, data: 8'($urandom),
                                  idx: 6'(i)});
      end
    end
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Well-formed string: dictionary codes and escape pairs, mostly closed by code 0.
  task automatic queue_string();
    logic [5:0] codes [$];
    logic bitq [$];
    logic [7:0] byte_v;
    int n_codes;
    int k;
    int b;
    if (stream_cnt[PLAN] != 0 || esc_pend[PLAN] || $urandom_range(0, 9) == 0)
      queue_item(sbdtd_pkg::KIND_RESTART, 8'($urandom), 6'($urandom));
    n_codes = $urandom_range(1, 10);
    for (k = 0; k < n_codes; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        codes.push_back(6'($urandom_range(int'(sbdtd_pkg::ESCAPE_FIRST), 63)));
        codes.push_back(6'($urandom_range(0, 63)));
      end else begin
        codes.push_back(6'($urandom_range(1, sbdtd_pkg::DICT_DEPTH)));
      end
    end
    if ($urandom_range(0, 9) != 0) codes.push_back(6'd0);
    for (k = 0; k < codes.size(); k++)
      for (b = 5; b >= 0; b--) bitq.push_back(codes[k][b]);
    while (bitq.size() % 8 != 0) bitq.push_back(1'($urandom));
    while (bitq.size() > 0) begin
      for (b = 0; b < 8; b++) byte_v = {byte_v[6:0], bitq.pop_front()};
      queue_item(sbdtd_pkg::KIND_DATA, byte_v, 6'($urandom));
    end
  endtask

  task automatic queue_noise();
    case ($urandom_range(0, 3))
      0: queue_item(sbdtd_pkg::KIND_DATA, 8'($urandom), 6'($urandom));
      1: queue_item(sbdtd_pkg::KIND_DICT, 8'($urandom), 6'($urandom));
      2: queue_item(sbdtd_pkg::KIND_RESTART, 8'($urandom), 6'($urandom));
      default: queue_item(KIND_UNUSED, 8'($urandom), 6'($urandom));
    endcase
  endtask

  task automatic queue_random(input int n_items);
    int start;
    start = items_queued;
    while (items_queued - start < n_items) begin
      if ($urandom_range(0, 99) < 80) queue_string();
      else queue_noise();
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin : drive_items
    in_item_t nxt;
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        in_kind <= nxt.kind;
        in_data_byte <= nxt.data;
        in_dict_index <= nxt.idx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_seen != hold_asks) begin
        hold_seen <= hold_asks;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_chars
    in_item_t acc;
    char_pair_t res;
    logic [sbdtd_pkg::DICT_DEPTH-1:0] reads;
    char_rec_t want;
    int n;
    int k;
    in_took = rst_n && in_valid && in_ready;
    out_took = rst_n && out_valid && out_ready;
    if (in_took) begin
      acc = '{kind: in_kind, data: in_data_byte, idx: in_dict_index};
      n = decode_item(LIVE, acc, res, reads);
      for (k = 0; k < n; k++) expected_chars.push_back(res[k]);
      items_taken++;
      if (n == 2) pair_items++;
    end
    if (out_took) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %02h", out_char_out));
      end else begin
        want = expected_chars.pop_front();
        if (out_char_out !== want.ch)
          report_mismatch($sformatf("char_out %02h, want %02h", out_char_out, want.ch));
        if (out_end_of_string !== want.eos)
          report_mismatch($sformatf("end_of_string %b, want %b (char %02h)",
                                    out_end_of_string, want.eos, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b, want %b (char %02h)",
                                    out_last, want.last, want.ch));
        chars_checked++;
        if (want.eos) eos_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took || out_took) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("six_bit_dictionary_text_decoder verification failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (dict_set[s, i]) begin
      dict_set[s][i] = 1'b0;
      dict_val[s][i] = '0;
    end
    for (int s = 0; s < 2; s++) begin
      stream_bits[s] = '0;
      stream_cnt[s] = '0;
      esc_pend[s] = 1'b0;
      esc_hi[s] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 7;
    recv_idle_pct = 73;
    // directed: field extremes, ignored items, escapes, mid-byte endings
    queue_item(sbdtd_pkg::KIND_DICT, 8'h00, 6'd0);
    queue_item(sbdtd_pkg::KIND_DICT, 8'hff, 6'd58);
    queue_item(sbdtd_pkg::KIND_DICT, 8'h5a, 6'd63);     // out of range, ignored
    queue_item(sbdtd_pkg::KIND_DICT, 8'hc3, 6'd59);     // out of range, ignored
    queue_item(KIND_UNUSED, 8'hff, 6'h3f);              // unknown kind, ignored
    queue_item(sbdtd_pkg::KIND_DATA, 8'h04, 6'h00);     // code 1
    queue_item(sbdtd_pkg::KIND_DATA, 8'hef, 6'h3f);
    queue_item(sbdtd_pkg::KIND_DATA, 8'hbf, 6'h15);     // escape pair inside one byte
    queue_item(sbdtd_pkg::KIND_DATA, 8'h00, 6'h2a);     // end of string on a byte boundary
    queue_item(sbdtd_pkg::KIND_DATA, 8'hf0, 6'h00);     // escape split across bytes
    queue_item(sbdtd_pkg::KIND_DATA, 8'h00, 6'h00);     // escape then zero: literal 00
    queue_item(sbdtd_pkg::KIND_DATA, 8'h0f, 6'h3f);     // end of string, second code dropped
    queue_item(sbdtd_pkg::KIND_DATA, 8'hff, 6'h01);
    queue_item(sbdtd_pkg::KIND_DATA, 8'hf0, 6'h02);     // escape then escape: literal ff
    queue_item(sbdtd_pkg::KIND_DATA, 8'h41, 6'h04);     // two characters from one byte
    queue_item(sbdtd_pkg::KIND_DATA, 8'heb, 6'h08);     // code 58
    queue_item(sbdtd_pkg::KIND_DATA, 8'hbf, 6'h10);     // code 59
    queue_item(sbdtd_pkg::KIND_RESTART, 8'hff, 6'h3f);
    queue_item(sbdtd_pkg::KIND_DATA, 8'hec, 6'h20);
    queue_item(sbdtd_pkg::KIND_DATA, 8'h3f, 6'h3f);
    queue_item(sbdtd_pkg::KIND_DATA, 8'hf0, 6'h3f);
    queue_item(sbdtd_pkg::KIND_DATA, 8'hf3, 6'h00);     // escape left pending
    queue_item(sbdtd_pkg::KIND_RESTART, 8'h00, 6'h00);  // restart clears the escape
    queue_item(sbdtd_pkg::KIND_DATA, 8'h00, 6'h00);     // so this ends the string
    queue_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct = 73;
    recv_idle_pct = 7;
    queue_random(PHASE_ITEMS);
    wait_drained();

    // no idling; receiver holds off long enough to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    queue_random(PHASE_ITEMS);
    wait_drained();

    repeat (20) @(posedge clk);
    $display("%0d items transferred; %0d characters checked, %0d string ends,",
             items_taken, chars_checked, eos_checked);
    $display("%0d items gave two characters; %0d mismatches", pair_items, mismatch_count);
    if (mismatch_count == 0) begin
      $display("six_bit_dictionary_text_decoder verification clean");
    end else begin
      $display("six_bit_dictionary_text_decoder verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sbdtd_pkg.sv
rtl/sbdtd_ram.sv
rtl/sbdtd_front.sv
rtl/sbdtd_fifo.sv
rtl/sbdtd_back.sv
rtl/six_bit_dictionary_text_decoder.sv
test/tb.sv
